// ===== design/hts_pkg.sv =====
// Package for the HTML tag stripper: parse modes, byte classes, character codes,
// the queue word type and the depth of the queue between the front and back ends.
// It depends on nothing else. Every module of the block imports it.
package hts_pkg;

  localparam int DEFAULT_MAX_DEPTH = 255;
  localparam int HIST_LEN          = 7;
  localparam int QUEUE_DEPTH       = 2;

  typedef enum logic [2:0] {
    MODE_TEXT    = 3'd0,
    MODE_TAG     = 3'd1,
    MODE_BANG    = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_SCRIPT  = 3'd4,
    MODE_STYLE   = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    CLS_NUL,
    CLS_LT,
    CLS_GT,
    CLS_T,
    CLS_QUOTE,
    CLS_BANG,
    CLS_E,
    CLS_DASH,
    CLS_OTHER
  } byte_class_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  data;
    logic [7:0]  data_lower;
    logic        start;
    logic        last;
  } queue_word_t;

  function automatic logic [7:0] lower_of(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

// ===== design/hts_front.sv =====
// Front end of the HTML tag stripper: takes input words and classifies each byte.
// Depends on hts_pkg; feeds the queue module hts_fifo.
module hts_front
  import hts_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        start_of_text,
  input  logic        end_of_text,
  input  logic        queue_full,
  output logic        push,
  output queue_word_t push_word
);

  byte_class_t cls;

  always_comb begin
    unique case (text_byte)
      CH_NUL:               cls = CLS_NUL;
      CH_LT:                cls = CLS_LT;
      CH_GT:                cls = CLS_GT;
      "t", "T":             cls = CLS_T;
      CH_DQUOTE, CH_SQUOTE: cls = CLS_QUOTE;
      CH_BANG:              cls = CLS_BANG;
      "e", "E":             cls = CLS_E;
      CH_DASH:              cls = CLS_DASH;
      default:              cls = CLS_OTHER;
    endcase
  end

  assign in_ready             = !queue_full;
  assign push                 = in_valid && !queue_full;
  assign push_word.cls        = cls;
  assign push_word.data       = text_byte;
  assign push_word.data_lower = lower_of(text_byte);
  assign push_word.start      = start_of_text;
  assign push_word.last       = end_of_text;

endmodule

// ===== design/hts_fifo.sv =====
// Short queue of classified words between the front and back ends.
// Depends on hts_pkg for the word type and the queue depth.
module hts_fifo
  import hts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  queue_word_t push_word,
  output logic        full,
  input  logic        pop,
  output queue_word_t pop_word,
  output logic        empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  queue_word_t   store [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = count == CW'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_word = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/hts_back.sv =====
// Back end of the HTML tag stripper: parse state, byte history and output register.
// Depends on hts_pkg; takes words from hts_fifo.
module hts_back
  import hts_pkg::*;
#(
  parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  queue_word_t pop_word,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kept,
  output logic [7:0]  kept_byte,
  output logic        last_of_text
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  mode_t              parse_mode, parse_mode_next;
  logic [DEPTH_W-1:0] tag_depth, tag_depth_next;
  logic               in_special, in_special_next;
  logic [7:0]         last_significant, last_significant_next;
  logic [7:0]         byte_history [HIST_LEN];
  logic [2:0]         position_count;
  logic               keep_next;

  mode_t              m;
  logic [DEPTH_W-1:0] d;
  logic               sp;
  logic [7:0]         ls;
  logic [7:0]         h [HIST_LEN];
  logic [2:0]         pos;
  logic               keep_path;
  logic               pat_script, pat_doctype, pat_style;

  assign pop = !empty && (!out_valid || out_ready);

  always_comb begin
    m   = pop_word.start ? MODE_TEXT : parse_mode;
    d   = pop_word.start ? '0 : tag_depth;
    sp  = pop_word.start ? 1'b0 : in_special;
    ls  = pop_word.start ? CH_NUL : last_significant;
    pos = pop_word.start ? 3'd0 : position_count;
    for (int k = 0; k < HIST_LEN; k++) begin
      h[k] = pop_word.start ? CH_NUL : byte_history[k];
    end

    // History holds lowered bytes, so these matches ignore case.
    pat_script  = h[0] == "p" && h[1] == "i" && h[2] == "r" && h[3] == "c" && h[4] == "s";
    pat_doctype = h[0] == "p" && h[1] == "y" && h[2] == "t" && h[3] == "c" && h[4] == "o"
                  && h[5] == "d";
    pat_style   = h[0] == "l" && h[1] == "y" && h[2] == "t" && h[3] == "s";

    parse_mode_next       = m;
    tag_depth_next        = d;
    in_special_next       = sp;
    last_significant_next = ls;
    keep_path             = 1'b0;

    unique case (pop_word.cls)
      CLS_NUL: begin
      end
      CLS_LT: begin
        if (m == MODE_TEXT) begin
          parse_mode_next = MODE_TAG;
        end else if (m == MODE_TAG && d < DEPTH_W'(MAX_DEPTH)) begin
          tag_depth_next = d + 1'b1;
        end
        if (!sp) begin
          last_significant_next = CH_LT;
        end
      end
      CLS_GT: begin
        if (m == MODE_TAG) begin
          if (d != '0) begin
            tag_depth_next = d - 1'b1;
          end else begin
            parse_mode_next = MODE_TEXT;
          end
          last_significant_next = CH_GT;
        end else if (m == MODE_COMMENT) begin
          if (ls == CH_LT) begin
            parse_mode_next = MODE_TEXT;
          end
          last_significant_next = CH_GT;
        end else if (m == MODE_SCRIPT || m == MODE_STYLE) begin
          if ((m == MODE_SCRIPT && ls == "t") || ls == "e") begin
            parse_mode_next = MODE_TEXT;
            in_special_next = 1'b0;
          end
          last_significant_next = CH_GT;
        end else begin
          keep_path = 1'b1;
        end
      end
      CLS_T: begin
        if (m == MODE_TAG && ls == CH_LT && pos > 3'd5 && pat_script) begin
          parse_mode_next = MODE_SCRIPT;
          in_special_next = 1'b1;
        end else if (m == MODE_SCRIPT && sp && ls != CH_SQUOTE && pos > 3'd5 && pat_script
                     && h[5] == CH_SLASH && h[6] != CH_BSLASH) begin
          last_significant_next = "t";
        end else begin
          keep_path = 1'b1;
        end
      end
      CLS_QUOTE: begin
        if (!sp || ls != CH_GT) begin
          last_significant_next = CH_SQUOTE;
        end
      end
      CLS_BANG: begin
        if (m == MODE_TAG) begin
          parse_mode_next = MODE_BANG;
        end else begin
          keep_path = 1'b1;
        end
      end
      CLS_E: begin
        if (m == MODE_BANG && pos > 3'd6 && pat_doctype) begin
          parse_mode_next = MODE_TAG;
        end else if (m == MODE_TAG && ls == CH_LT && pos > 3'd5 && pat_style) begin
          parse_mode_next = MODE_STYLE;
          in_special_next = 1'b1;
        end else if (m == MODE_STYLE && sp && ls != CH_SQUOTE && pos > 3'd5 && pat_style
                     && h[4] == CH_SLASH && h[5] != CH_BSLASH) begin
          last_significant_next = "e";
        end else begin
          keep_path = 1'b1;
        end
      end
      CLS_DASH: begin
        if (m == MODE_BANG && h[0] == CH_DASH) begin
          parse_mode_next = MODE_COMMENT;
        end else begin
          keep_path = 1'b1;
        end
      end
      default: begin
        keep_path = 1'b1;
      end
    endcase

    // A kept byte never changes the mode, so the mode it saw still holds.
    keep_next = keep_path && m == MODE_TEXT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode       <= MODE_TEXT;
      tag_depth        <= '0;
      in_special       <= 1'b0;
      last_significant <= CH_NUL;
      position_count   <= 3'd0;
      for (int k = 0; k < HIST_LEN; k++) begin
        byte_history[k] <= CH_NUL;
      end
    end else if (pop) begin
      parse_mode       <= parse_mode_next;
      tag_depth        <= tag_depth_next;
      in_special       <= in_special_next;
      last_significant <= last_significant_next;
      position_count   <= (pos == 3'd7) ? pos : pos + 1'b1;
      byte_history[0]  <= pop_word.data_lower;
      for (int k = 1; k < HIST_LEN; k++) begin
        byte_history[k] <= h[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kept         <= keep_next;
      kept_byte    <= keep_next ? pop_word.data : CH_NUL;
      last_of_text <= pop_word.last;
    end
  end

  a_special_mode: assert property (@(posedge clk) disable iff (rst)
    in_special == (parse_mode == MODE_SCRIPT || parse_mode == MODE_STYLE))
    else $error("in_special disagrees with the parse mode");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    tag_depth <= DEPTH_W'(MAX_DEPTH))
    else $error("tag depth above its limit");

  a_pop_fills_output: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped word did not reach the output register");

  a_kept_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kept ? kept_byte != CH_NUL : kept_byte == CH_NUL))
    else $error("kept_byte does not match kept");

  a_position_step: assert property (@(posedge clk) disable iff (rst)
    pop && !pop_word.start && position_count != 3'd7 |=>
      position_count == $past(position_count) + 3'd1)
    else $error("position count did not advance");

endmodule

// ===== design/html_tag_stripper.sv =====
// Top level of the HTML tag stripper: front end, word queue and back end.
// Depends on hts_pkg, hts_front, hts_fifo and hts_back.
//
//   channel | handshake            | word
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_ready  | text_byte, start_of_text, end_of_text
//   output  | out_valid / out_ready| kept, kept_byte, last_of_text
//
// One byte per cycle sustained while out_ready stays high; an accepted byte is queued,
// then popped into the output register; the back end's parse update is combinational.
// Reset is synchronous and clears the parse state and the queue; no clearing pass.
// A stalled output holds its word while the two-entry queue keeps taking input
// until it fills, then in_ready drops.
module html_tag_stripper
  import hts_pkg::*;
#(
  parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       start_of_text,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kept,
  output logic [7:0] kept_byte,
  output logic       last_of_text
);

  queue_word_t push_word;
  queue_word_t pop_word;
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        queue_empty;

  hts_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .start_of_text (start_of_text),
    .end_of_text   (end_of_text),
    .queue_full    (queue_full),
    .push          (push),
    .push_word     (push_word)
  );

  hts_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (queue_full),
    .pop       (pop),
    .pop_word  (pop_word),
    .empty     (queue_empty)
  );

  hts_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (queue_empty),
    .pop_word     (pop_word),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kept         (kept),
    .kept_byte    (kept_byte),
    .last_of_text (last_of_text)
  );

endmodule
